/* hdl/stcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stair climb detector package
// Shared request and result types, phase, command, event and register codes, and register defaults.
// ----------------------------------------------------------------------------
package stcd_pkg;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic [1:0]         g_event_kind;
  } stcd_in_t;

  typedef struct packed {
    logic [15:0] stair_total;
    logic [2:0]  phase_code;
    logic        stair_added;
    logic        timer_running;
  } stcd_out_t;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ACTIVE = 3'd1;
  localparam logic [2:0] PH_DOWN   = 3'd2;
  localparam logic [2:0] PH_UP     = 3'd3;
  localparam logic [2:0] PH_COUNT  = 3'd4;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_EVENT  = 2'd2;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_POS  = 2'd1;
  localparam logic [1:0] EV_NEG  = 2'd2;
  localparam logic [1:0] EV_BAD  = 2'd3;

  localparam logic [2:0] REG_DOWN_EXIT = 3'd0;
  localparam logic [2:0] REG_UP_EXIT   = 3'd1;
  localparam logic [2:0] REG_X_MAX     = 3'd2;
  localparam logic [2:0] REG_X_MIN     = 3'd3;
  localparam logic [2:0] REG_YZ_MAX    = 3'd4;
  localparam logic [2:0] REG_TIMEOUT   = 3'd5;
  localparam logic [2:0] REG_SHORT_SEQ = 3'd6;

  localparam logic signed [15:0] RST_DOWN_EXIT = 16'sd4505;
  localparam logic signed [15:0] RST_UP_EXIT   = 16'sd5324;
  localparam logic signed [15:0] RST_X_MAX     = 16'sd12288;
  localparam logic signed [15:0] RST_X_MIN     = -16'sd4096;
  localparam logic [16:0]        RST_YZ_MAX    = 17'd4096;
  localparam logic [15:0]        RST_TIMEOUT   = 16'd200;
  localparam logic [15:0]        RST_SHORT_SEQ = 16'd20;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

endpackage : stcd_pkg
`default_nettype wire

/* hdl/stair_climb_detector.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stair climb detector
// Counts stairs from accelerometer samples, timer ticks and g events.
// ----------------------------------------------------------------------------
// Pipeline: a request is captured in the input register; its result is then
// registered into the output register, or into the skid buffer on a stall.
// Throughput: one request per cycle unless stalled; the state update is one
// pass of compare logic from input register to two-entry result buffer.
// Reset: synchronous, active low; clears the phase, tick count, stair count,
// pending event and buffers, and restores the register defaults.
module stair_climb_detector
  import stcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire stcd_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output stcd_out_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic signed [15:0] down_exit_r, up_exit_r, x_max_r, x_min_r;
  logic [16:0]        yz_max_r;
  logic [15:0]        timeout_r, short_seq_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] stair_r, stair_nxt;
  logic [1:0]  pend_r, pend_nxt;

  logic      s1_valid_r;
  stcd_in_t  s1_data_r;
  logic      out_valid_r, skid_valid_r;
  stcd_out_t out_data_r, skid_data_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       in_take, s1_drain, out_free;
  stcd_out_t  res;

  logic [1:0]         kind;
  logic signed [16:0] yz_sum;
  logic [16:0]        yz_abs;
  logic               go_idle;
  logic               added;
  logic signed [15:0] x;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_exit_r <= RST_DOWN_EXIT;
      up_exit_r   <= RST_UP_EXIT;
      x_max_r     <= RST_X_MAX;
      x_min_r     <= RST_X_MIN;
      yz_max_r    <= RST_YZ_MAX;
      timeout_r   <= RST_TIMEOUT;
      short_seq_r <= RST_SHORT_SEQ;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DOWN_EXIT: down_exit_r <= pwdata[15:0];
        REG_UP_EXIT:   up_exit_r   <= pwdata[15:0];
        REG_X_MAX:     x_max_r     <= pwdata[15:0];
        REG_X_MIN:     x_min_r     <= pwdata[15:0];
        REG_YZ_MAX:    yz_max_r    <= pwdata[16:0];
        REG_TIMEOUT:   timeout_r   <= pwdata[15:0];
        REG_SHORT_SEQ: short_seq_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DOWN_EXIT: prdata = {{16{down_exit_r[15]}}, down_exit_r};
      REG_UP_EXIT:   prdata = {{16{up_exit_r[15]}}, up_exit_r};
      REG_X_MAX:     prdata = {{16{x_max_r[15]}}, x_max_r};
      REG_X_MIN:     prdata = {{16{x_min_r[15]}}, x_min_r};
      REG_YZ_MAX:    prdata = {15'd0, yz_max_r};
      REG_TIMEOUT:   prdata = {16'd0, timeout_r};
      REG_SHORT_SEQ: prdata = {16'd0, short_seq_r};
      default:       prdata = 32'd0;
    endcase
  end

  assign in_stall = s1_valid_r & skid_valid_r;
  assign in_take  = in_valid & ~in_stall;
  assign s1_drain = s1_valid_r & ~skid_valid_r;
  assign out_free = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_drain) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
  end

  always_comb begin
    x         = s1_data_r.acc_x;
    kind      = (s1_data_r.g_event_kind == EV_BAD) ? EV_NONE : s1_data_r.g_event_kind;
    yz_sum    = 17'(s1_data_r.acc_y) + 17'(s1_data_r.acc_z);
    yz_abs    = yz_sum[16] ? 17'(-yz_sum) : 17'(yz_sum);
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    stair_nxt = stair_r;
    pend_nxt  = pend_r;
    go_idle   = 1'b0;
    added     = 1'b0;
    unique case (s1_data_r.command)
      CMD_SAMPLE: begin
        if (phase_r != PH_IDLE) begin
          priority if (tick_r >= timeout_r) begin
            tick_nxt = 16'd0;
            go_idle  = 1'b1;
          end else if (x > x_max_r || x < x_min_r) begin
            go_idle = 1'b1;
          end else if (yz_abs > yz_max_r) begin
            go_idle = 1'b1;
          end else begin
            unique case (phase_r)
              PH_ACTIVE: begin
                if (x > down_exit_r) phase_nxt = PH_DOWN;
              end
              PH_DOWN: begin
                if (x < down_exit_r) go_idle = 1'b1;
                else if (x > up_exit_r) phase_nxt = PH_UP;
              end
              PH_UP: begin
                if (x < up_exit_r) phase_nxt = PH_COUNT;
              end
              PH_COUNT: begin
                if (tick_r > short_seq_r && stair_r != CNT_MAX) begin
                  stair_nxt = stair_r + 16'd1;
                  added     = 1'b1;
                end
                go_idle = 1'b1;
              end
              default: go_idle = 1'b1;
            endcase
          end
        end
        if (go_idle) begin
          pend_nxt = EV_NONE;
          if (pend_r == EV_NEG) begin
            phase_nxt = PH_ACTIVE;
            tick_nxt  = 16'd0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      CMD_TICK: begin
        if (phase_r != PH_IDLE && tick_r != CNT_MAX) tick_nxt = tick_r + 16'd1;
      end
      CMD_EVENT: begin
        if (phase_r == PH_IDLE) begin
          if (kind == EV_NEG) begin
            phase_nxt = PH_ACTIVE;
            tick_nxt  = 16'd0;
          end
        end else if (kind != EV_NONE) begin
          pend_nxt = kind;
        end
      end
      default: ;
    endcase
    res.stair_total   = stair_nxt;
    res.phase_code    = phase_nxt;
    res.stair_added   = added;
    res.timer_running = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= 16'd0;
      stair_r <= 16'd0;
      pend_r  <= EV_NONE;
    end else if (s1_drain) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      stair_r <= stair_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= s1_drain;
      end
    end else if (s1_drain) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (s1_drain) begin
        out_data_r <= res;
      end
    end else if (s1_drain) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : stair_climb_detector
`default_nettype wire

/* hdl/stcd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stair climb detector checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module stcd_prop_checker
  import stcd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire stcd_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  a_timer_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.timer_running == (out_data.phase_code != PH_IDLE)))
    else $error("timer flag disagrees with phase");

  a_added_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stair_added |->
      (out_data.phase_code == PH_IDLE || out_data.phase_code == PH_ACTIVE))
    else $error("stair added without leaving the count step");

  a_added_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stair_added |-> out_data.stair_total != 16'd0)
    else $error("stair added but total is zero");

endmodule : stcd_prop_checker

bind stair_climb_detector stcd_prop_checker u_stcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

/* test/stcd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stair climb detector checker
// Watches the request, result and register ports of the detector. It keeps
// its own copy of the registers and of the detector state, predicts the
// status that each accepted request must produce, and compares every
// returned status with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module stcd_checker
  import stcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  stcd_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  stcd_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          open_count
);

  logic signed [15:0] down_lvl;
  logic signed [15:0] up_lvl;
  logic signed [15:0] x_hi;
  logic signed [15:0] x_lo;
  logic [16:0]        yz_lim;
  logic [15:0]        tick_limit;
  logic [15:0]        short_limit;

  logic [2:0]  phase;
  logic [15:0] ticks;
  logic [15:0] stairs;
  logic [1:0]  latched_ev;

  stcd_out_t status_queue[$];
  int        mismatches = 0;

  // A latched negative-g event re-arms the detector as soon as it falls idle.
  function automatic void drop_to_idle();
    phase = PH_IDLE;
    if (latched_ev == EV_NEG) begin
      phase = PH_ACTIVE;
      ticks = '0;
    end
    latched_ev = EV_NONE;
  endfunction

  function automatic stcd_out_t advance_detector(stcd_in_t req);
    logic signed [15:0] x;
    logic signed [17:0] yz_sum;
    logic signed [17:0] yz_neg;
    logic [16:0]        yz_mag;
    logic [1:0]         kind;
    stcd_out_t          res;
    res = '0;
    x = req.acc_x;
    kind = (req.g_event_kind == EV_BAD) ? EV_NONE : req.g_event_kind;
    yz_sum = {{2{req.acc_y[15]}}, req.acc_y} + {{2{req.acc_z[15]}}, req.acc_z};
    yz_neg = -yz_sum;
    yz_mag = yz_sum[17] ? yz_neg[16:0] : yz_sum[16:0];
    case (req.command)
      CMD_SAMPLE: begin
        if (phase != PH_IDLE) begin
          if (ticks >= tick_limit) begin
            ticks = '0;
            drop_to_idle();
          end else if (x > x_hi || x < x_lo || yz_mag > yz_lim) begin
            drop_to_idle();
          end else begin
            case (phase)
              PH_ACTIVE: begin
                if (x > down_lvl) phase = PH_DOWN;
              end
              PH_DOWN: begin
                if (x > up_lvl) phase = PH_UP;
                if (x < down_lvl) drop_to_idle();
              end
              PH_UP: begin
                if (x < up_lvl) phase = PH_COUNT;
              end
              PH_COUNT: begin
                if (ticks > short_limit && stairs != CNT_MAX) begin
                  stairs = stairs + 16'd1;
                  res.stair_added = 1'b1;
                end
                drop_to_idle();
              end
              default: begin
                drop_to_idle();
              end
            endcase
          end
        end
      end
      CMD_TICK: begin
        if (phase != PH_IDLE && ticks != CNT_MAX) ticks = ticks + 16'd1;
      end
      CMD_EVENT: begin
        if (phase == PH_IDLE) begin
          if (kind == EV_NEG) begin
            phase = PH_ACTIVE;
            ticks = '0;
          end
        end else if (kind != EV_NONE) begin
          latched_ev = kind;
        end
      end
      default: ;
    endcase
    res.stair_total   = stairs;
    res.phase_code    = phase;
    res.timer_running = (phase != PH_IDLE);
    return res;
  endfunction

  function automatic void compare_field(string field, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    stcd_out_t want;
    if (!rst_n) begin
      down_lvl    = RST_DOWN_EXIT;
      up_lvl      = RST_UP_EXIT;
      x_hi        = RST_X_MAX;
      x_lo        = RST_X_MIN;
      yz_lim      = RST_YZ_MAX;
      tick_limit  = RST_TIMEOUT;
      short_limit = RST_SHORT_SEQ;
      phase       = PH_IDLE;
      ticks       = '0;
      stairs      = '0;
      latched_ev  = EV_NONE;
      status_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_DOWN_EXIT: down_lvl    = pwdata[15:0];
          REG_UP_EXIT:   up_lvl      = pwdata[15:0];
          REG_X_MAX:     x_hi        = pwdata[15:0];
          REG_X_MIN:     x_lo        = pwdata[15:0];
          REG_YZ_MAX:    yz_lim      = pwdata[16:0];
          REG_TIMEOUT:   tick_limit  = pwdata[15:0];
          REG_SHORT_SEQ: short_limit = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (status_queue.size() == 0) begin
          mismatches++;
          $display("%0t ns: status with no request pending, expected none, got %h",
                   $time, out_data);
        end else begin
          want = status_queue.pop_front();
          compare_field("stair_total", want.stair_total, out_data.stair_total);
          compare_field("phase_code", want.phase_code, out_data.phase_code);
          compare_field("stair_added", want.stair_added, out_data.stair_added);
          compare_field("timer_running", want.timer_running, out_data.timer_running);
        end
      end
      if (in_valid && !in_stall) status_queue.push_back(advance_detector(in_data));
    end
    fail_count <= mismatches;
    open_count <= status_queue.size();
  end

endmodule : stcd_checker

/* test/stair_climb_detector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stair climb detector testbench
// Drives the detector with a directed opening, then mostly well-formed climb
// sequences with random content under a series of register settings.
// Both channels idle at random; a separate checker predicts every status.
// ----------------------------------------------------------------------------
module stair_climb_detector_tb;
  import stcd_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         STUCK_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  stcd_in_t    in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  stcd_out_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int checked_fail;
  int open_results;
  int stuck_cycles = 0;
  int sent_total = 0;
  bit idle_en = 1'b1;

  int down_cfg, up_cfg, xmax_cfg, xmin_cfg, yz_cfg, timeout_cfg, short_cfg;

  stair_climb_detector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  stcd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (checked_fail),
    .open_count (open_results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= idle_en && ($urandom_range(99) < 20);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int rnd16();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int pick_in(int lo, int hi);
    if (lo > hi) return rnd16();
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic send_req(input logic [1:0] cmd, input int x, input int y, input int z,
                          input logic [1:0] kind);
    stcd_in_t req;
    req.command      = cmd;
    req.acc_x        = x[15:0];
    req.acc_y        = y[15:0];
    req.acc_z        = z[15:0];
    req.g_event_kind = kind;
    while (idle_en && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_total++;
  endtask

  task automatic send_sample(input int x, input int y, input int z);
    send_req(CMD_SAMPLE, x, y, z, 2'($urandom_range(3)));
  endtask

  task automatic send_tick();
    send_req(CMD_TICK, rnd16(), rnd16(), rnd16(), 2'($urandom_range(3)));
  endtask

  task automatic send_event(input logic [1:0] kind);
    send_req(CMD_EVENT, rnd16(), rnd16(), rnd16(), kind);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic set_config(input int d, input int u, input int xh, input int xl,
                            input int yz, input int to, input int sh);
    down_cfg    = d;
    up_cfg      = u;
    xmax_cfg    = xh;
    xmin_cfg    = xl;
    yz_cfg      = yz;
    timeout_cfg = to;
    short_cfg   = sh;
    write_reg(REG_DOWN_EXIT, {16'h0, d[15:0]});
    write_reg(REG_UP_EXIT,   {16'h0, u[15:0]});
    write_reg(REG_X_MAX,     {16'h0, xh[15:0]});
    write_reg(REG_X_MIN,     {16'h0, xl[15:0]});
    write_reg(REG_YZ_MAX,    {15'h0, yz[16:0]});
    write_reg(REG_TIMEOUT,   {16'h0, to[15:0]});
    write_reg(REG_SHORT_SEQ, {16'h0, sh[15:0]});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // With swapped levels the down exit lies above the up exit, so one sample
  // can satisfy both exits of the down phase.
  task automatic random_config(input bit swapped);
    int d, u;
    d = $urandom_range(8000, 2000);
    u = swapped ? d - int'($urandom_range(3000, 1)) : d + int'($urandom_range(4000));
    set_config(d, u, d + 5000 + int'($urandom_range(9000)), -int'($urandom_range(8000)),
               $urandom_range(20000), 1 + $urandom_range(80), $urandom_range(40));
  endtask

  // One arm, step and count attempt, with tick bursts around the short
  // sequence limit and an occasional event or off-target sample.
  task automatic climb_attempt();
    int burst, lo, hi, x, y, t, yzm;
    burst = ((short_cfg + 6 < 70) ? short_cfg + 6 : 70) / 2;
    yzm = (yz_cfg < 16383) ? yz_cfg : 16383;
    send_event(($urandom_range(9) == 0) ? 2'($urandom_range(3)) : EV_NEG);
    for (int stage = 0; stage < 4; stage++) begin
      repeat ($urandom_range(burst)) send_tick();
      if ($urandom_range(19) == 0) send_event(2'($urandom_range(3)));
      case (stage)
        0: begin
          lo = down_cfg + 1;
          hi = xmax_cfg;
        end
        1: begin
          lo = up_cfg + 1;
          hi = xmax_cfg;
        end
        2: begin
          lo = xmin_cfg;
          hi = up_cfg - 1;
        end
        default: begin
          lo = xmin_cfg;
          hi = xmax_cfg;
        end
      endcase
      if (lo < xmin_cfg) lo = xmin_cfg;
      if (hi > xmax_cfg) hi = xmax_cfg;
      x = ($urandom_range(11) == 0) ? rnd16() : pick_in(lo, hi);
      y = int'($urandom_range(32767)) - 16384;
      t = pick_in(-yzm, yzm);
      if ($urandom_range(11) == 0) begin
        send_sample(x, rnd16(), rnd16());
      end else begin
        send_sample(x, y, t - y);
      end
    end
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = sent_total + count;
    while (sent_total < stop_at) begin
      if ($urandom_range(99) < 75) begin
        climb_attempt();
      end else begin
        send_req(2'($urandom_range(3)), rnd16(), rnd16(), rnd16(), 2'($urandom_range(3)));
      end
    end
    drain();
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(4505, 5324, 12288, -4096, 4096, 3, 1);
    send_req(CMD_SAMPLE, 32767, -32768, -32768, EV_NONE);
    send_tick();
    send_event(EV_POS);
    send_event(EV_BAD);
    send_req(CMD_UNUSED, -1, -1, -1, EV_BAD);
    send_event(EV_NEG);
    send_tick();
    send_tick();
    send_event(EV_POS);
    send_event(EV_NEG);
    send_sample(5000, 100, -100);
    send_sample(6000, -32768, 32767);
    send_sample(0, 0, 0);
    send_sample(0, 0, 0);
    send_sample(-32768, 0, 0);
    send_event(EV_NEG);
    send_sample(0, 32767, 32767);
    send_event(EV_NEG);
    send_sample(12289, 0, 0);
    send_event(EV_NEG);
    send_sample(5000, 0, 0);
    send_sample(4000, 0, 0);
    send_event(EV_NEG);
    repeat (3) send_tick();
    send_sample(0, 0, 0);
    drain();

    set_config(4505, 5324, 12288, -4096, 4096, 60, 5);
    run_random(250);
    idle_en <= 1'b0;
    random_config(1'b0);
    run_random(250);
    idle_en <= 1'b1;
    random_config(1'b0);
    run_random(250);
    random_config(1'b0);
    run_random(250);
    random_config(1'b1);
    run_random(200);
    set_config(-32768, 32767, 32767, -32768, 65536, 65535, 65535);
    run_random(150);
    set_config(32767, -32768, 32767, -32768, 0, 1, 0);
    run_random(100);

    repeat (10) @(posedge clk);
    if (checked_fail == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : stair_climb_detector_tb
